// ----- rtl/owtr_pkg.sv -----
// ----------------------------------------------------------------------------
// owtr_pkg
// Shared types and constants of the one-wire temperature reader: register
// indexes, bus command bytes, slot timing, error codes and channel records.
// ----------------------------------------------------------------------------
package owtr_pkg;

   // configuration register indexes
   localparam logic [2:0] REG_BUS_ATTACHED       = 3'd0;
   localparam logic [2:0] REG_CONVERSION_WAIT_US = 3'd1;
   localparam logic [2:0] REG_RESET_LOW_US       = 3'd2;
   localparam logic [2:0] REG_PRESENCE_SAMPLE_US = 3'd3;
   localparam logic [2:0] REG_RESET_TAIL_US      = 3'd4;

   // bus command bytes
   localparam logic [7:0] CMD_SKIP_ROM        = 8'hCC;
   localparam logic [7:0] CMD_CONVERT         = 8'h44;
   localparam logic [7:0] CMD_READ_SCRATCHPAD = 8'hBE;

   // slot timing in microseconds
   localparam logic [19:0] SLOT_SHORT_LOW = 20'd6;
   localparam logic [19:0] SLOT_LONG_LOW  = 20'd60;
   localparam logic [19:0] SLOT_SAMPLE    = 20'd15;
   localparam logic [19:0] SLOT_LAST      = 20'd69;

   // number of scratchpad bytes read back
   localparam int         SCRATCHPAD_BYTES = 9;
   localparam logic [3:0] SCRATCH_COUNT    = 4'(SCRATCHPAD_BYTES);

   // error codes
   localparam logic [1:0] ERR_NONE         = 2'd0;
   localparam logic [1:0] ERR_NO_PRESENCE  = 2'd1;
   localparam logic [1:0] ERR_NOT_ATTACHED = 2'd2;

   typedef struct packed {
      logic        bus_attached;
      logic [19:0] conversion_wait_us;
      logic [9:0]  reset_low_us;
      logic [7:0]  presence_sample_us;
      logic [9:0]  reset_tail_us;
   } config_type;

   typedef struct packed {
      logic signed [15:0] temperature_raw;
      logic [1:0]         error_code;
      logic               done_res;
      logic               busy_res;
      logic               drive_low;
   } result_type;

endpackage

// ----- rtl/owtr_core.sv -----
// ----------------------------------------------------------------------------
// owtr_core
// Bus sequencer: advances one microsecond per transfer and forms the result
// of that tick from the current state and the sampled line.
// ----------------------------------------------------------------------------
module owtr_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  tick,
   input  logic                  start_request,
   input  logic                  line_sample,
   input  owtr_pkg::config_type  cfg,
   output owtr_pkg::result_type  result
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_RESET,
      PH_WRITE,
      PH_WAIT,
      PH_READ
   } phase_type;

   localparam logic [2:0] STEP_FIRST_RESET  = 3'd0;
   localparam logic [2:0] STEP_SKIP_FIRST   = 3'd1;
   localparam logic [2:0] STEP_CONVERT      = 3'd2;
   localparam logic [2:0] STEP_WAIT         = 3'd3;
   localparam logic [2:0] STEP_SECOND_RESET = 3'd4;
   localparam logic [2:0] STEP_SKIP_SECOND  = 3'd5;
   localparam logic [2:0] STEP_READ_CMD     = 3'd6;
   localparam logic [2:0] STEP_READ_DATA    = 3'd7;

   phase_type   phase_ff, phase_in, ph;
   logic [19:0] time_ff, time_in, tc;
   logic [2:0]  bit_ff, bit_in, bi;
   logic [3:0]  byte_ff, byte_in, by;
   logic [7:0]  shift_ff, shift_in, sb;
   logic [2:0]  step_ff, step_in, cs;
   logic [15:0] temp_ff, temp_in, tw;

   logic        launch;
   logic [10:0] sample_at;
   logic [11:0] reset_end;
   logic [20:0] wait_next;
   logic [7:0]  read_byte;
   logic [3:0]  byte_next;
   logic [15:0] temp_new;

   always_comb begin
      launch    = (phase_ff == PH_IDLE) && start_request;
      sample_at = {1'b0, cfg.reset_low_us} + {3'b000, cfg.presence_sample_us};
      reset_end = {1'b0, sample_at} + {2'b00, cfg.reset_tail_us};

      ph = phase_ff;
      tc = time_ff;
      bi = bit_ff;
      by = byte_ff;
      sb = shift_ff;
      cs = step_ff;
      tw = temp_ff;

      result = '0;

      if (launch) begin
         if (!cfg.bus_attached) begin
            result.done_res   = 1'b1;
            result.error_code = owtr_pkg::ERR_NOT_ATTACHED;
         end else begin
            ph = PH_RESET;
            tc = '0;
            cs = STEP_FIRST_RESET;
            bi = '0;
            by = '0;
            sb = '0;
            tw = '0;
         end
      end

      phase_in = ph;
      time_in  = tc;
      bit_in   = bi;
      byte_in  = by;
      shift_in = sb;
      step_in  = cs;
      temp_in  = tw;

      wait_next = {1'b0, tc} + 21'd1;
      read_byte = (tc == owtr_pkg::SLOT_SAMPLE) ? {line_sample, sb[7:1]} : sb;
      byte_next = by + 4'd1;
      temp_new  = tw;
      if (by == 4'd0) begin
         temp_new[7:0] = read_byte;
      end else if (by == 4'd1) begin
         temp_new[15:8] = read_byte;
      end

      result.busy_res = (ph != PH_IDLE);

      unique case (ph)
         PH_RESET: begin
            result.drive_low = tc < {10'd0, cfg.reset_low_us};
            if (tc == {9'd0, sample_at} && line_sample) begin
               result.done_res   = 1'b1;
               result.error_code = owtr_pkg::ERR_NO_PRESENCE;
               phase_in = PH_IDLE;
               time_in  = '0;
            end else if (tc >= {8'd0, reset_end}) begin
               step_in  = (cs == STEP_FIRST_RESET) ? STEP_SKIP_FIRST : STEP_SKIP_SECOND;
               phase_in = PH_WRITE;
               shift_in = owtr_pkg::CMD_SKIP_ROM;
               bit_in   = '0;
               time_in  = '0;
            end else begin
               time_in = tc + 20'd1;
            end
         end
         PH_WRITE: begin
            result.drive_low = sb[0] ? (tc < owtr_pkg::SLOT_SHORT_LOW)
                                     : (tc < owtr_pkg::SLOT_LONG_LOW);
            if (tc >= owtr_pkg::SLOT_LAST) begin
               time_in  = '0;
               shift_in = {1'b0, sb[7:1]};
               if (bi == 3'd7) begin
                  case (cs)
                     STEP_SKIP_FIRST: begin
                        step_in  = STEP_CONVERT;
                        shift_in = owtr_pkg::CMD_CONVERT;
                        bit_in   = '0;
                     end
                     STEP_CONVERT: begin
                        if (cfg.conversion_wait_us == 20'd0) begin
                           step_in  = STEP_SECOND_RESET;
                           phase_in = PH_RESET;
                        end else begin
                           step_in  = STEP_WAIT;
                           phase_in = PH_WAIT;
                        end
                     end
                     STEP_SKIP_SECOND: begin
                        step_in  = STEP_READ_CMD;
                        shift_in = owtr_pkg::CMD_READ_SCRATCHPAD;
                        bit_in   = '0;
                     end
                     default: begin
                        step_in  = STEP_READ_DATA;
                        phase_in = PH_READ;
                        byte_in  = '0;
                        bit_in   = '0;
                        shift_in = '0;
                     end
                  endcase
               end else begin
                  bit_in = bi + 3'd1;
               end
            end else begin
               time_in = tc + 20'd1;
            end
         end
         PH_WAIT: begin
            time_in = wait_next[19:0];
            if (wait_next >= {1'b0, cfg.conversion_wait_us}) begin
               step_in  = STEP_SECOND_RESET;
               phase_in = PH_RESET;
               time_in  = '0;
            end
         end
         PH_READ: begin
            result.drive_low = tc < owtr_pkg::SLOT_SHORT_LOW;
            shift_in = read_byte;
            if (tc >= owtr_pkg::SLOT_LAST) begin
               time_in = '0;
               if (bi == 3'd7) begin
                  bit_in   = '0;
                  temp_in  = temp_new;
                  byte_in  = byte_next;
                  shift_in = '0;
                  if (byte_next >= owtr_pkg::SCRATCH_COUNT) begin
                     result.done_res        = 1'b1;
                     result.error_code      = owtr_pkg::ERR_NONE;
                     result.temperature_raw = temp_new;
                     phase_in = PH_IDLE;
                  end
               end else begin
                  bit_in = bi + 3'd1;
               end
            end else begin
               time_in = tc + 20'd1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         time_ff  <= '0;
         bit_ff   <= '0;
         byte_ff  <= '0;
         shift_ff <= '0;
         step_ff  <= '0;
         temp_ff  <= '0;
      end else if (tick) begin
         phase_ff <= phase_in;
         time_ff  <= time_in;
         bit_ff   <= bit_in;
         byte_ff  <= byte_in;
         shift_ff <= shift_in;
         step_ff  <= step_in;
         temp_ff  <= temp_in;
      end
   end

endmodule

// ----- rtl/one_wire_temperature_reader.sv -----
// ----------------------------------------------------------------------------
// one_wire_temperature_reader
// One-wire bus master that runs one temperature read per start request.
// ----------------------------------------------------------------------------
// Each transfer on the req_ channel is one microsecond of bus time carrying
// a start request and the sampled line level. Every such transfer yields
// exactly one transfer on the rsp_ channel with the bus drive level, busy,
// done, an error code and the raw temperature in sixteenths of a degree.
// A start in idle with the bus attached sends a reset pulse, skip-ROM and
// convert, waits the conversion time, resets again, sends skip-ROM and
// read-scratchpad and reads the scratchpad bytes; done reports the result
// on its finishing tick. A req_ transfer's rsp_ item is held in the output
// register from the next cycle. Throughput is one tick per cycle while the
// receiver keeps up, set by the single sequencer update between the state
// registers and the output register. When the receiver stalls, req_tready
// drops only while the output register is full and not taken, so no tick
// is lost and the sequencer simply waits. Reset (synchronous) returns the
// sequencer to idle, empties the output register, loads the configuration
// defaults. csr_ writes take effect at the clock edge they are presented.
// ----------------------------------------------------------------------------
module one_wire_temperature_reader (
   input  logic        clock,
   input  logic        reset,
   // configuration port
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [19:0] csr_write_data,
   // tick input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // start_request, line_sample
   // tick result
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // drive_low, busy_res, done_res, error_code, temperature_raw
);

   owtr_pkg::config_type cfg_ff;
   owtr_pkg::result_type result;
   owtr_pkg::result_type rsp_data_ff;
   logic                 rsp_valid_ff;
   logic                 req_transfer;

   assign req_tready   = !rsp_valid_ff || rsp_tready;
   assign req_transfer = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bus_attached       <= 1'b0;
         cfg_ff.conversion_wait_us <= 20'd750000;
         cfg_ff.reset_low_us       <= 10'd480;
         cfg_ff.presence_sample_us <= 8'd70;
         cfg_ff.reset_tail_us      <= 10'd410;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            owtr_pkg::REG_BUS_ATTACHED:       cfg_ff.bus_attached <= csr_write_data[0];
            owtr_pkg::REG_CONVERSION_WAIT_US: cfg_ff.conversion_wait_us <= csr_write_data;
            owtr_pkg::REG_RESET_LOW_US:       cfg_ff.reset_low_us <= csr_write_data[9:0];
            owtr_pkg::REG_PRESENCE_SAMPLE_US: cfg_ff.presence_sample_us <= csr_write_data[7:0];
            owtr_pkg::REG_RESET_TAIL_US:      cfg_ff.reset_tail_us <= csr_write_data[9:0];
            default: begin
            end
         endcase
      end
   end

   owtr_core u_core (
      .clock         (clock),
      .reset         (reset),
      .tick          (req_transfer),
      .start_request (req_tdata[0]),
      .line_sample   (req_tdata[1]),
      .cfg           (cfg_ff),
      .result        (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_transfer) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_transfer) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff};

endmodule
